/* rtl/bta_pkg.sv */
// shared types, constants and the digit-to-character function of the binary to ascii converter
`timescale 1ns / 1ps

package bta_pkg;

  // input and output field widths
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CHAR_W  = 7;

  // ten bcd digits cover the full 32-bit range
  localparam int unsigned DEC_DIGITS = 10;
  localparam int unsigned HEX_DIGITS = 8;
  localparam int unsigned DIGITS_W   = 4 * DEC_DIGITS;

  // shift-add-3 runs one step per input bit
  localparam int unsigned STEP_W = $clog2(VALUE_W);

  // digit count and prefix count widths
  localparam int unsigned LEFT_W = $clog2(DEC_DIGITS + 1);
  localparam int unsigned PRE_W  = 2;

  localparam logic [PRE_W-1:0]  PREFIX_LEN = PRE_W'(2);
  localparam logic [LEFT_W-1:0] DEC_LEN    = LEFT_W'(DEC_DIGITS);
  localparam logic [LEFT_W-1:0] HEX_LEN    = LEFT_W'(HEX_DIGITS);

  // ascii codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_X    = 7'h78;
  localparam logic [CHAR_W-1:0] CHAR_A_OFS = 7'h37;

  // mode codes
  localparam logic MODE_HEX = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // digit word handed to the character sequencer
  typedef struct packed {
    logic                valid;
    logic                dec;
    logic [DIGITS_W-1:0] digits;
  } bta_load_t;

  // one digit 0..15 to its upper-case character
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] ch;
    if (nib < 4'd10) begin
      ch = CHAR_ZERO + {3'b000, nib};
    end else begin
      ch = CHAR_A_OFS + {3'b000, nib};
    end
    return ch;
  endfunction

endpackage

/* rtl/binary_to_ascii_hex_or_decimal.sv */
// top level: binary to ascii converter, "0x" plus eight hex digits or plain decimal
//
//   channel  direction  payload                    handshake
//   in_      input      in_value[31:0], in_mode    in_valid / in_stall
//   out_     output     out_ascii_char[6:0], out_last  out_valid / out_stall
//
// one item at a time; in_stall rises at a transfer and falls in the cycle after the last
// character has entered the output register. a hex item is ten characters; a decimal
// item runs the shift-add-3 steps, one per input bit, then loads the sequencer, which
// drops leading zeros and emits digits, ten together. out_stall holds the output
// register and the sequencer's characters, but leading zeros are still dropped under
// it. rst_n is synchronous; no clearing pass is needed.
`timescale 1ns / 1ps

module binary_to_ascii_hex_or_decimal (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bta_pkg::VALUE_W-1:0]   in_value,
  input  logic                          in_mode,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bta_pkg::CHAR_W-1:0]    out_ascii_char,
  output logic                          out_last
);
  import bta_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic                accept;
  logic                dab_start;
  logic                dab_done;
  logic [DIGITS_W-1:0] dab_bcd;
  logic                emit_busy;
  bta_load_t           load;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign dab_start = accept && (in_mode == MODE_DEC);

  // hex goes straight to the sequencer, decimal after the bcd conversion
  always_comb begin
    load = '0;
    if (state_r == ST_IDLE && accept && in_mode == MODE_HEX) begin
      load.valid  = 1'b1;
      load.dec    = 1'b0;
      load.digits = {in_value, {(DIGITS_W - VALUE_W){1'b0}}};
    end else if (state_r == ST_CONV && dab_done) begin
      load.valid  = 1'b1;
      load.dec    = 1'b1;
      load.digits = dab_bcd;
    end
  end

  // control sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_mode == MODE_DEC) ? ST_CONV : ST_EMIT;
        end
      end
      ST_CONV: begin
        if (dab_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!emit_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  bta_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dab_start),
    .value (in_value),
    .done  (dab_done),
    .bcd   (dab_bcd)
  );

  bta_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load),
    .busy           (emit_busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ascii_char (out_ascii_char),
    .out_last       (out_last)
  );

endmodule

/* rtl/bta_dabble.sv */
// iterative shift-add-3 unit: 32-bit binary to ten bcd digits, one bit per cycle
`timescale 1ns / 1ps

module bta_dabble (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bta_pkg::VALUE_W-1:0]   value,
  output logic                          done,
  output logic [bta_pkg::DIGITS_W-1:0]  bcd
);
  import bta_pkg::*;

  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [VALUE_W-1:0]  bin_r, bin_nxt;
  logic [DIGITS_W-1:0] bcd_r, bcd_nxt;
  logic [DIGITS_W-1:0] corr;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < DEC_DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        corr[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        corr[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  // step sequencer
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = '0;
      bin_nxt  = value;
      bcd_nxt  = '0;
    end else if (run_r) begin
      bcd_nxt  = {corr[DIGITS_W-2:0], bin_r[VALUE_W-1]};
      bin_nxt  = {bin_r[VALUE_W-2:0], 1'b0};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(VALUE_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

/* rtl/bta_emit.sv */
// character sequencer: prefix, leading-zero skip and the registered output stage
`timescale 1ns / 1ps

module bta_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bta_pkg::bta_load_t          load,
  output logic                        busy,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bta_pkg::CHAR_W-1:0]  out_ascii_char,
  output logic                        out_last
);
  import bta_pkg::*;

  logic                busy_r, busy_nxt;
  logic                lead_r, lead_nxt;
  logic [PRE_W-1:0]    pre_r, pre_nxt;
  logic [LEFT_W-1:0]   left_r, left_nxt;
  logic [DIGITS_W-1:0] dig_r, dig_nxt;
  logic                oval_r, oval_nxt;
  logic [CHAR_W-1:0]   ochar_r, ochar_nxt;
  logic                olast_r, olast_nxt;
  logic                out_free;
  logic [3:0]          top;

  assign out_free = !oval_r || !out_stall;
  assign top      = dig_r[DIGITS_W-1 -: 4];

  // one character while the output register is free, or one skipped leading zero, per cycle
  always_comb begin
    busy_nxt  = busy_r;
    lead_nxt  = lead_r;
    pre_nxt   = pre_r;
    left_nxt  = left_r;
    dig_nxt   = dig_r;
    oval_nxt  = oval_r;
    ochar_nxt = ochar_r;
    olast_nxt = olast_r;
    if (oval_r && !out_stall) begin
      oval_nxt = 1'b0;
    end
    if (load.valid) begin
      busy_nxt = 1'b1;
      lead_nxt = load.dec;
      pre_nxt  = load.dec ? '0 : PREFIX_LEN;
      left_nxt = load.dec ? DEC_LEN : HEX_LEN;
      dig_nxt  = load.digits;
    end else if (busy_r) begin
      if (pre_r != '0) begin
        // "0x" prefix in hex mode
        if (out_free) begin
          oval_nxt  = 1'b1;
          ochar_nxt = (pre_r == PREFIX_LEN) ? CHAR_ZERO : CHAR_X;
          olast_nxt = 1'b0;
          pre_nxt   = pre_r - 1'b1;
        end
      end else if (lead_r && top == 4'd0 && left_r > LEFT_W'(1)) begin
        // drop a leading zero, keeping at least one digit
        dig_nxt  = {dig_r[DIGITS_W-5:0], 4'h0};
        left_nxt = left_r - 1'b1;
      end else if (out_free) begin
        oval_nxt  = 1'b1;
        ochar_nxt = hex_char(top);
        olast_nxt = (left_r == LEFT_W'(1));
        dig_nxt   = {dig_r[DIGITS_W-5:0], 4'h0};
        left_nxt  = left_r - 1'b1;
        lead_nxt  = 1'b0;
        busy_nxt  = (left_r != LEFT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      oval_r <= oval_nxt;
    end
    lead_r  <= lead_nxt;
    pre_r   <= pre_nxt;
    left_r  <= left_nxt;
    dig_r   <= dig_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  assign busy           = busy_r;
  assign out_valid      = oval_r;
  assign out_ascii_char = ochar_r;
  assign out_last       = olast_r;

endmodule

/* tb/sv/ascii_run_checker.sv */
// checker for the binary to ascii converter: predicts character runs and compares transfers
`timescale 1ns / 1ps

module ascii_run_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [bta_pkg::VALUE_W-1:0] in_value,
  input  logic                        in_mode,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [bta_pkg::CHAR_W-1:0]  out_ascii_char,
  input  logic                        out_last,
  output int                          errors,
  output int                          pending
);

  import bta_pkg::*;

  // one expected character of a run
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              fin;
  } run_char_t;

  run_char_t char_q[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // print one mismatch line and count it
  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    errors++;
  endtask

  // digit 0..15 to its upper-case ascii code
  function automatic logic [CHAR_W-1:0] digit_code(input logic [3:0] d);
    if (d < 4'd10) begin
      return CHAR_W'(8'h30 + d);
    end
    return CHAR_W'(8'h41 + d - 4'd10);
  endfunction

  // append the characters that one number formats to
  function automatic void format_number(input logic [VALUE_W-1:0] v, input logic m);
    logic [VALUE_W-1:0] rem;
    logic [3:0]         dec_digits[$];
    run_char_t          rc;
    int                 i;
    if (m == MODE_HEX) begin
      // "0x" then eight digits, leading zeros kept
      rc.fin = 1'b0;
      rc.ch  = CHAR_W'(8'h30);
      char_q.push_back(rc);
      rc.ch  = CHAR_W'(8'h78);
      char_q.push_back(rc);
      for (i = HEX_DIGITS - 1; i >= 0; i--) begin
        rc.ch  = digit_code(v[i*4 +: 4]);
        rc.fin = (i == 0);
        char_q.push_back(rc);
      end
    end else if (v == '0) begin
      // zero in decimal is a lone '0'
      rc.ch  = CHAR_W'(8'h30);
      rc.fin = 1'b1;
      char_q.push_back(rc);
    end else begin
      // decimal digits, no leading zeros
      rem = v;
      while (rem != '0) begin
        dec_digits.push_front(4'(rem % 10));
        rem = rem / 10;
      end
      for (i = 0; i < dec_digits.size(); i++) begin
        rc.ch  = digit_code(dec_digits[i]);
        rc.fin = (i == dec_digits.size() - 1);
        char_q.push_back(rc);
      end
    end
  endfunction

  // watch both channels
  always @(posedge clk) begin
    run_char_t want;
    if (rst_n) begin
      // input transfer: predict its run
      if (in_valid && !in_stall) begin
        format_number(in_value, in_mode);
      end
      // output transfer: compare with the oldest expected character
      if (out_valid && !out_stall) begin
        if (char_q.size() == 0) begin
          report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                    out_ascii_char, out_last));
        end else begin
          want = char_q.pop_front();
          if (out_ascii_char !== want.ch) begin
            report_mismatch($sformatf("ascii_char 0x%02h, expected 0x%02h",
                                      out_ascii_char, want.ch));
          end
          if (out_last !== want.fin) begin
            report_mismatch($sformatf("last %0b, expected %0b on char 0x%02h",
                                      out_last, want.fin, want.ch));
          end
        end
      end
    end
    pending <= char_q.size();
  end

endmodule

/* tb/sv/testbench.sv */
// testbench top: clock, reset, number stimulus, output stalls and the verdict
`timescale 1ns / 1ps

module testbench;

  import bta_pkg::*;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic [VALUE_W-1:0]  in_value       = '0;
  logic                in_mode        = MODE_HEX;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [CHAR_W-1:0]   out_ascii_char;
  logic                out_last;
  int                  errors;
  int                  pending;

  // idling controls
  logic                quiet          = 1'b0;
  logic                in_gaps_on     = 1'b1;
  logic                out_stall_on   = 1'b1;

  always #5 clk = ~clk;

  binary_to_ascii_hex_or_decimal i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_mode        (in_mode),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ascii_char (out_ascii_char),
    .out_last       (out_last)
  );

  ascii_run_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_mode        (in_mode),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ascii_char (out_ascii_char),
    .out_last       (out_last),
    .errors         (errors),
    .pending        (pending)
  );

  // offer one number and hold it until its transfer, then maybe idle
  task automatic send_number(input logic [VALUE_W-1:0] v, input logic m);
    in_value <= v;
    in_mode  <= m;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (!quiet && in_gaps_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      in_value <= $urandom;
      in_mode  <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // receiver stalls in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && out_stall_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // stimulus and verdict
  initial begin
    logic [VALUE_W-1:0] v;
    logic [63:0]        pow;
    int                 n;
    int                 k;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zeros, extremes, every hex letter, decimal length boundaries
    send_number(32'h0000_0000, MODE_HEX);
    send_number(32'h0000_0000, MODE_DEC);
    send_number(32'hFFFF_FFFF, MODE_HEX);
    send_number(32'hFFFF_FFFF, MODE_DEC);
    send_number(32'h0123_4567, MODE_HEX);
    send_number(32'h89AB_CDEF, MODE_HEX);
    send_number(32'hFEDC_BA98, MODE_HEX);
    send_number(32'h8000_0000, MODE_HEX);
    send_number(32'h8000_0000, MODE_DEC);
    send_number(32'h0000_0001, MODE_HEX);
    send_number(32'd1, MODE_DEC);
    send_number(32'd9, MODE_DEC);
    send_number(32'd10, MODE_DEC);
    send_number(32'd99, MODE_DEC);
    send_number(32'd100, MODE_DEC);
    send_number(32'd65535, MODE_DEC);
    send_number(32'd999_999_999, MODE_DEC);
    send_number(32'd1_000_000_000, MODE_DEC);
    send_number(32'd1_234_567_890, MODE_DEC);
    send_number(32'd4_294_967_294, MODE_DEC);
    send_number(32'h5555_5555, MODE_DEC);
    send_number(32'hAAAA_AAAA, MODE_HEX);

    // random numbers of every decimal length: full range, shifted down, near powers of ten, small
    for (n = 0; n < 158; n++) begin
      if (n % 16 == 0) begin
        in_gaps_on   <= $urandom_range(0, 3) != 0;
        out_stall_on <= $urandom_range(0, 3) != 0;
      end
      if (n == 130) begin
        quiet <= 1'b1;
      end
      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: v = $urandom >> $urandom_range(0, 31);
        2: begin
          // just around a power of ten
          pow = 64'd1;
          for (k = $urandom_range(1, 9); k > 0; k--) begin
            pow = pow * 10;
          end
          v = VALUE_W'(pow + $urandom_range(0, 2) - 1);
        end
        default: v = $urandom_range(0, 1000);
      endcase
      send_number(v, 1'($urandom_range(0, 1)));
    end
    in_valid <= 1'b0;

    // drain, then allow the block's latency
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (errors == 0) begin
      $display("** binary_to_ascii_hex_or_decimal: PASSED **");
    end else begin
      $display("** binary_to_ascii_hex_or_decimal: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("** binary_to_ascii_hex_or_decimal: FAILED **");
    $finish;
  end

endmodule
